FILE: src/s256_pkg.sv
// Shared types, codes and constants of the SHA-256 stream hash.
package s256_pkg;

  // Depth of the item queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  // Block layout and padding.
  localparam logic [5:0] FILL_LAST  = 6'd63;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [2:0] LAST_IDX   = 3'd7;

  // Item kind carried in tuser.
  typedef enum logic {
    OP_ABSORB = 1'b0,
    OP_FINISH = 1'b1
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } item_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_ROUND,
    ENG_FOLD
  } eng_state_t;

  typedef enum logic [1:0] {
    BK_TAKE,
    BK_PAD,
    BK_COMP,
    BK_EMIT
  } back_state_t;

  // Commands from the back controller to the compression engine.
  typedef struct packed {
    logic start;
    logic reinit;
  } eng_cmd_t;

  // Status from the compression engine.
  typedef struct packed {
    logic busy;
    logic done;
  } eng_stat_t;

  // Initial hash values; element 0 is H0, listed last.
  localparam logic [7:0][31:0] IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  // Round constants, round 0 first.
  localparam logic [31:0] K_TABLE [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

FILE: src/s256_queue.sv
// Item queue that decouples the input front from the hashing back end.
module s256_queue #(
  parameter int DEPTH = s256_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  s256_pkg::item_t in_item,
  output logic            out_valid,
  input  logic            out_pop,
  output s256_pkg::item_t out_item
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  s256_pkg::item_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_item  = mem[rd_ptr];
  assign do_push   = in_valid && in_ready;
  assign do_pop    = out_pop && out_valid;

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= in_item;
    end
  end

endmodule

FILE: src/s256_compress.sv
// SHA-256 compression engine, one round per cycle, holding the hash words.
module s256_compress (
  input  logic                  clk,
  input  logic                  rst,
  input  s256_pkg::eng_cmd_t    cmd,
  input  logic [15:0][31:0]     block,
  output s256_pkg::eng_stat_t   stat,
  output logic [7:0][31:0]      hash
);

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  s256_pkg::eng_state_t state;
  s256_pkg::eng_state_t state_next;
  logic [5:0]           rnd;
  logic [15:0][31:0]    w;
  logic [7:0][31:0]     v;
  logic [7:0][31:0]     hw;
  logic [31:0]          t1;
  logic [31:0]          t2;
  logic [31:0]          w_new;
  logic [31:0]          choose;
  logic [31:0]          major;

  assign hash = hw;

  // Round function and message schedule for the current round.
  always_comb begin
    choose = (v[4] & v[5]) ^ (~v[4] & v[6]);
    major  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1     = v[7] + big_sigma1(v[4]) + choose + s256_pkg::K_TABLE[rnd] + w[0];
    t2     = big_sigma0(v[0]) + major;
    w_new  = w[0] + small_sigma0(w[1]) + w[9] + small_sigma1(w[14]);
  end

  // Engine state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= s256_pkg::ENG_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and status.
  always_comb begin
    state_next = state;
    stat.busy  = (state != s256_pkg::ENG_IDLE);
    stat.done  = (state == s256_pkg::ENG_FOLD);
    unique case (state)
      s256_pkg::ENG_IDLE: begin
        if (cmd.start) state_next = s256_pkg::ENG_ROUND;
      end
      s256_pkg::ENG_ROUND: begin
        if (rnd == s256_pkg::ROUND_LAST) state_next = s256_pkg::ENG_FOLD;
      end
      s256_pkg::ENG_FOLD: begin
        state_next = s256_pkg::ENG_IDLE;
      end
      default: begin
        state_next = s256_pkg::ENG_IDLE;
      end
    endcase
  end

  // Hash words: reset and reinit load the initial values, a fold adds the rounds.
  always_ff @(posedge clk) begin
    if (rst) begin
      hw <= s256_pkg::IV;
    end else if (state == s256_pkg::ENG_FOLD) begin
      for (int i = 0; i < 8; i++) begin
        hw[i] <= hw[i] + v[i];
      end
    end else if (state == s256_pkg::ENG_IDLE && cmd.reinit) begin
      hw <= s256_pkg::IV;
    end
  end

  // Working variables, schedule window and round counter.
  always_ff @(posedge clk) begin
    if (state == s256_pkg::ENG_IDLE && cmd.start) begin
      for (int i = 0; i < 16; i++) begin
        w[i] <= block[15 - i];
      end
      v   <= hw;
      rnd <= '0;
    end else if (state == s256_pkg::ENG_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i + 1];
      end
      w[15] <= w_new;
      v[7]  <= v[6];
      v[6]  <= v[5];
      v[5]  <= v[4];
      v[4]  <= v[3] + t1;
      v[3]  <= v[2];
      v[2]  <= v[1];
      v[1]  <= v[0];
      v[0]  <= t1 + t2;
      rnd   <= rnd + 6'd1;
    end
  end

endmodule

FILE: src/s256_back.sv
// Back end: block assembly, padding sequencer and digest output register.
module s256_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_pop,
  input  s256_pkg::item_t     q_item,
  output s256_pkg::eng_cmd_t  eng_cmd,
  input  s256_pkg::eng_stat_t eng_stat,
  input  logic [7:0][31:0]    hash,
  output logic [15:0][31:0]   block,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         digest_word,
  output logic [2:0]          word_index,
  output logic                last_word
);

  s256_pkg::back_state_t state;
  s256_pkg::back_state_t state_next;
  logic [63:0][7:0]      blk;
  logic [5:0]            fill;
  logic [60:0]           bytes_hashed;
  logic [7:0][7:0]       bit_len;
  logic                  padding;
  logic                  final_blk;
  logic                  comp_final;
  logic [2:0]            out_idx;
  logic [31:0]           out_word;
  logic                  push;
  logic [7:0]            push_byte;
  logic                  out_xfer;

  // The engine sees the buffer with the byte that is pushed this cycle.
  assign block       = {blk[62:0], push_byte};
  assign out_xfer    = out_valid && out_ready;
  assign digest_word = out_word;
  assign word_index  = out_idx;
  assign last_word   = (out_idx == s256_pkg::LAST_IDX);

  // Back state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= s256_pkg::BK_TAKE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, byte push and engine commands.
  always_comb begin
    state_next     = state;
    q_pop          = 1'b0;
    push           = 1'b0;
    push_byte      = '0;
    eng_cmd.reinit = 1'b0;
    unique case (state)
      s256_pkg::BK_TAKE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          push      = 1'b1;
          push_byte = (q_item.op == s256_pkg::OP_FINISH) ? s256_pkg::PAD_MARK : q_item.data;
          if (fill == s256_pkg::FILL_LAST) begin
            state_next = s256_pkg::BK_COMP;
          end else if (q_item.op == s256_pkg::OP_FINISH) begin
            state_next = s256_pkg::BK_PAD;
          end
        end
      end
      s256_pkg::BK_PAD: begin
        push = 1'b1;
        if (final_blk && fill >= s256_pkg::LEN_POS) begin
          push_byte = bit_len[3'd7 - fill[2:0]];
        end
        if (fill == s256_pkg::FILL_LAST) state_next = s256_pkg::BK_COMP;
      end
      s256_pkg::BK_COMP: begin
        if (eng_stat.done) begin
          if (comp_final) begin
            state_next = s256_pkg::BK_EMIT;
          end else if (padding) begin
            state_next = s256_pkg::BK_PAD;
          end else begin
            state_next = s256_pkg::BK_TAKE;
          end
        end
      end
      s256_pkg::BK_EMIT: begin
        if (out_xfer && out_idx == s256_pkg::LAST_IDX) begin
          state_next     = s256_pkg::BK_TAKE;
          eng_cmd.reinit = 1'b1;
        end
      end
      default: begin
        state_next = s256_pkg::BK_TAKE;
      end
    endcase
    eng_cmd.start = push && (fill == s256_pkg::FILL_LAST);
  end

  // Control state: fill count, length count, padding flags and output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill         <= '0;
      bytes_hashed <= '0;
      padding      <= 1'b0;
      final_blk    <= 1'b0;
      comp_final   <= 1'b0;
      out_valid    <= 1'b0;
      out_idx      <= '0;
    end else begin
      if (push) fill <= fill + 6'd1;
      if (state == s256_pkg::BK_TAKE && q_valid) begin
        if (q_item.op == s256_pkg::OP_ABSORB) begin
          bytes_hashed <= bytes_hashed + 61'd1;
        end else begin
          // The block with the marker is final unless the length no longer fits;
          // a marker in the last byte closes this block and opens the final one.
          bytes_hashed <= '0;
          padding      <= 1'b1;
          final_blk    <= (fill < s256_pkg::LEN_POS) || (fill == s256_pkg::FILL_LAST);
          comp_final   <= 1'b0;
        end
      end
      if (state == s256_pkg::BK_PAD && fill == s256_pkg::FILL_LAST) begin
        if (final_blk) begin
          comp_final <= 1'b1;
        end else begin
          final_blk <= 1'b1;
        end
      end
      if (state == s256_pkg::BK_EMIT) begin
        if (!out_valid) begin
          out_valid <= 1'b1;
        end else if (out_ready) begin
          if (out_idx == s256_pkg::LAST_IDX) begin
            out_valid  <= 1'b0;
            out_idx    <= '0;
            padding    <= 1'b0;
            final_blk  <= 1'b0;
            comp_final <= 1'b0;
          end else begin
            out_idx <= out_idx + 3'd1;
          end
        end
      end
    end
  end

  // Payload: byte shift line, latched bit length and output word.
  always_ff @(posedge clk) begin
    if (push) blk <= {blk[62:0], push_byte};
    if (state == s256_pkg::BK_TAKE && q_valid && q_item.op == s256_pkg::OP_FINISH) begin
      bit_len <= {bytes_hashed, 3'b000};
    end
    if (state == s256_pkg::BK_EMIT) begin
      if (!out_valid) begin
        out_word <= hash[out_idx];
      end else if (out_ready) begin
        out_word <= hash[out_idx + 3'd1];
      end
    end
  end

endmodule

FILE: src/sha256_stream_hash.sv
// Top level of the SHA-256 stream hash: input queue, back end and compression engine.
//
//   channel  direction  tdata fields (low bit up)                 tuser  tlast
//   s_*      in         data_byte[7:0]                            op     -
//   m_*      out        digest_word[31:0], word_index[34:32], 0s  -      last_word
//
// An absorb byte is popped and pushed into the shift line; the 64th byte of a
// block starts the compression engine, which runs one round per cycle and then
// folds the working variables into the hash words. A finish pushes padding one
// byte per cycle through the same shift line, with one or two compressions, then
// sends eight words, one per cycle while m_tready is high, after loading the
// first. The input queue keeps taking bytes during that time until its four
// entries are full; a low m_tready holds the back end in the digest output for
// as long as it stays low.
// Reset is synchronous and returns the hash words to the initial values.
module sha256_stream_hash #(
  parameter int QUEUE_DEPTH = s256_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte[7:0]
  input  logic        s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // digest_word[31:0], word_index[34:32], zero fill
  output logic        m_tlast
);

  s256_pkg::item_t     in_item;
  s256_pkg::item_t     q_item;
  logic                q_valid;
  logic                q_pop;
  s256_pkg::eng_cmd_t  eng_cmd;
  s256_pkg::eng_stat_t eng_stat;
  logic [7:0][31:0]    hash;
  logic [15:0][31:0]   block;
  logic [31:0]         digest_word;
  logic [2:0]          word_index;

  // Classify the incoming transfer by its kind.
  always_comb begin
    in_item.op   = s_tuser ? s256_pkg::OP_FINISH : s256_pkg::OP_ABSORB;
    in_item.data = s_tdata;
  end

  s256_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (in_item),
    .out_valid(q_valid),
    .out_pop  (q_pop),
    .out_item (q_item)
  );

  s256_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item),
    .eng_cmd    (eng_cmd),
    .eng_stat   (eng_stat),
    .hash       (hash),
    .block      (block),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .digest_word(digest_word),
    .word_index (word_index),
    .last_word  (m_tlast)
  );

  s256_compress u_compress (
    .clk  (clk),
    .rst  (rst),
    .cmd  (eng_cmd),
    .block(block),
    .stat (eng_stat),
    .hash (hash)
  );

  assign m_tdata = {5'b00000, word_index, digest_word};

  // The back end never takes an item while a compression is running.
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && eng_stat.busy))
    else $error("queue popped during compression");

  // Digest words follow each other in order without a gap.
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=>
      (m_tvalid && m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1))
    else $error("digest word index did not advance");

  // The last flag marks exactly the eighth word.
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[34:32] == s256_pkg::LAST_IDX)))
    else $error("last flag and word index disagree");

  // No compression is started while one is running.
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    eng_cmd.start |-> !eng_stat.busy)
    else $error("compression started while busy");

endmodule

FILE: test/sha256_stream_hash_test.sv
// Self-checking testbench for the SHA-256 stream hash: random byte messages, digest checks.
`timescale 1ns / 100ps

module sha256_stream_hash_test;

  // Initial hash values, H0 first.
  localparam bit [31:0] HASH_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Round constants of the standard, round 0 first.
  localparam bit [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam bit [7:0] PAD_BYTE     = 8'h80;
  localparam int       LEN_OFFSET   = 56;
  localparam int       LONG_HOLD    = 400;
  localparam int       DRAIN_CYCLES = 300;
  localparam int       RANDOM_ITEMS = 160;
  localparam int       MIN_MESSAGES = 8;

  typedef struct {
    bit [31:0] word;
    bit [2:0]  pos;
    bit        last;
  } digest_t;

  // Tracks the running hash of the current message and the digest words still owed.
  class digest_scoreboard;
    bit [31:0] hash_st [8];
    bit [7:0]  blk [64];
    bit [5:0]  fill;
    bit [60:0] byte_count;
    digest_t   pending [$];
    int        errors;
    int        messages;
    int        data_bytes;
    int        words_checked;

    function new();
      errors = 0;
      messages = 0;
      data_bytes = 0;
      words_checked = 0;
      restart();
    endfunction

    function void restart();
      hash_st = HASH_INIT;
      fill = '0;
      byte_count = '0;
    endfunction

    function bit [31:0] rotr(bit [31:0] v, int n);
      return (v >> n) | (v << (32 - n));
    endfunction

    // One 64-round compression of the block buffer into the hash words.
    function void compress_block();
      bit [31:0] w [64];
      bit [31:0] v [8];
      bit [31:0] s0, s1, t1, t2;
      for (int t = 0; t < 16; t++) begin
        w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
      end
      for (int t = 16; t < 64; t++) begin
        s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
        s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
        w[t] = w[t-16] + s0 + w[t-7] + s1;
      end
      v = hash_st;
      for (int t = 0; t < 64; t++) begin
        s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
        t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
        s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
        t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      for (int k = 0; k < 8; k++) begin
        hash_st[k] = hash_st[k] + v[k];
      end
    endfunction

    // Called for every accepted input transfer.
    function void note_item(s256_pkg::op_t op, bit [7:0] data_byte);
      bit [63:0] bit_len;
      int        i;
      digest_t   d;
      if (op == s256_pkg::OP_ABSORB) begin
        blk[fill] = data_byte;
        fill = fill + 1'b1;
        byte_count = byte_count + 1'b1;
        data_bytes++;
        if (fill == 0) begin
          compress_block();
        end
        return;
      end
      // Pad with the marker byte, zeros and the bit length; a second block is
      // needed when the length field no longer fits behind the marker.
      bit_len = {byte_count, 3'b000};
      i = fill;
      blk[i] = PAD_BYTE;
      i++;
      if (i > LEN_OFFSET) begin
        while (i < 64) begin
          blk[i] = 8'h00;
          i++;
        end
        compress_block();
        i = 0;
      end
      while (i < LEN_OFFSET) begin
        blk[i] = 8'h00;
        i++;
      end
      for (int k = 0; k < 8; k++) begin
        blk[LEN_OFFSET + k] = bit_len[63 - 8*k -: 8];
      end
      compress_block();
      for (int k = 0; k < 8; k++) begin
        d.word = hash_st[k];
        d.pos = k[2:0];
        d.last = (k == 7);
        pending.push_back(d);
      end
      messages++;
      restart();
    endfunction

    // Called for every accepted output transfer.
    function void check_word(bit [39:0] tdata, bit tlast);
      digest_t d;
      if (pending.size() == 0) begin
        $display("%0t: unexpected digest word: expected none, actual %h last %b",
                 $time, tdata, tlast);
        errors++;
        return;
      end
      d = pending.pop_front();
      words_checked++;
      if (tdata[31:0] !== d.word) begin
        $display("%0t: digest_word: expected %h, actual %h", $time, d.word, tdata[31:0]);
        errors++;
      end
      if (tdata[34:32] !== d.pos) begin
        $display("%0t: word_index: expected %0d, actual %0d", $time, d.pos, tdata[34:32]);
        errors++;
      end
      if (tlast !== d.last) begin
        $display("%0t: last_word: expected %b, actual %b", $time, d.last, tlast);
        errors++;
      end
      if (tdata[39:35] !== 5'b0) begin
        $display("%0t: tdata fill: expected 00, actual %h", $time, tdata[39:35]);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        m_tlast;

  digest_scoreboard board;
  int burst_left;
  int items_sent;
  int hold_asked;
  int hold_done;

  sha256_stream_hash u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // data_byte[7:0]
    .s_tuser  (s_tuser),   // op
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // digest_word[31:0], word_index[34:32], zero fill
    .m_tlast  (m_tlast)
  );

  // Clock.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Watch both channels; inputs are noted before outputs are checked.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        board.note_item(s256_pkg::op_t'(s_tuser), s_tdata);
      end
      if (m_tvalid && m_tready) begin
        board.check_word(m_tdata, m_tlast);
      end
    end
  end

  // Offer one item, idling first when the current burst is used up.
  task automatic send_item(s256_pkg::op_t op, bit [7:0] data_byte);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      repeat (gap) begin
        @(negedge clk);
        s_tvalid = 1'b0;
      end
      burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 8);
    end
    burst_left--;
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata = data_byte;
    s_tuser = op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_message(int len);
    for (int k = 0; k < len; k++) begin
      send_item(s256_pkg::OP_ABSORB, 8'($urandom_range(0, 255)));
    end
    send_item(s256_pkg::OP_FINISH, 8'($urandom_range(0, 255)));
  endtask

  // Stop offering and wait for every digest word still owed.
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // Receiver: picks at random among always ready, coin toss and one in four,
  // with one long hold when the sender asks for it.
  initial begin
    int mode;
    int span;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(20, 80);
      repeat (span) begin
        @(negedge clk);
        if (hold_asked != hold_done) begin
          hold_done++;
          m_tready = 1'b0;
          repeat (LONG_HOLD) @(negedge clk);
        end
        case (mode)
          0: begin
            m_tready = 1'b1;
          end
          1: begin
            m_tready = 1'($urandom_range(0, 1));
          end
          default: begin
            m_tready = ($urandom_range(0, 3) == 0);
          end
        endcase
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int len;
    board = new();
    burst_left = 0;
    items_sent = 0;
    hold_asked = 0;
    hold_done = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'h00;
    s_tuser = s256_pkg::OP_ABSORB;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty message with a junk byte on the finish, single extreme
    // bytes, the classic three-byte message, and an empty message right after.
    send_item(s256_pkg::OP_FINISH, 8'ha5);
    send_item(s256_pkg::OP_ABSORB, 8'h00);
    send_item(s256_pkg::OP_FINISH, 8'hff);
    send_item(s256_pkg::OP_ABSORB, 8'hff);
    send_item(s256_pkg::OP_FINISH, 8'h00);
    send_item(s256_pkg::OP_ABSORB, 8'h61);
    send_item(s256_pkg::OP_ABSORB, 8'h62);
    send_item(s256_pkg::OP_ABSORB, 8'h63);
    send_item(s256_pkg::OP_FINISH, 8'h5a);
    send_item(s256_pkg::OP_FINISH, 8'h00);
    wait_drained();

    // A short message first so that the long receiver hold backs up the input.
    hold_asked++;
    send_message($urandom_range(0, 3));

    // Random messages, biased toward the block and padding boundaries.
    while (items_sent < RANDOM_ITEMS || board.messages < MIN_MESSAGES) begin
      case ($urandom_range(0, 3))
        0: begin
          case ($urandom_range(0, 7))
            0: len = 55;
            1: len = 56;
            2: len = 57;
            3: len = 63;
            4: len = 64;
            5: len = 65;
            6: len = 119;
            default: len = 120;
          endcase
        end
        default: begin
          len = $urandom_range(0, 24);
        end
      endcase
      send_message(len);
      if (board.messages == 6) begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Hashed %0d messages over %0d data bytes, including block and padding edges,",
             board.messages, board.data_bytes);
    $display("and checked %0d digest words under random input gaps and output stalls.",
             board.words_checked);
    if (board.errors == 0) begin
      $display("sha256_stream_hash_test: done, clean");
    end else begin
      $display("sha256_stream_hash_test: done, errors");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #5000000;
    $display("sha256_stream_hash_test: done, errors");
    $finish;
  end

endmodule

FILE: sim.f
src/s256_pkg.sv
src/s256_queue.sv
src/s256_compress.sv
src/s256_back.sv
src/sha256_stream_hash.sv
test/sha256_stream_hash_test.sv
